// File: rtl/nrcc_pkg.sv
// ----------------------------------------------------------------------------
// nrcc_pkg
// Shared constants and types for the nearest reference colour classifier.
// ----------------------------------------------------------------------------
`default_nettype none
package nrcc_pkg;
    localparam int MAX_COLORS_DEF = 6;
    localparam int REG_SLOTS = 6;
    localparam int CHAN_W = 16;
    localparam int SUM_W = 34;
    localparam int MAG_W = 17;
    localparam int DIST_W = 16;
    localparam logic [DIST_W-1:0] NO_MATCH_DIST = 16'hFFFF;
    localparam logic [15:0] THRESH_RESET = 16'd5000;
    localparam logic [2:0] COUNT_RESET = 3'd6;
    localparam logic [3:0] REG_THRESH = 4'd0;
    localparam logic [3:0] REG_COUNT = 4'd1;
    localparam logic [3:0] REG_COLOR0 = 4'd2;
    localparam logic [9:0] W_RED = 10'd900;
    localparam logic [11:0] W_GREEN = 12'd3481;
    localparam logic [6:0] W_BLUE = 7'd121;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } norm_t;
endpackage
`default_nettype wire

// File: rtl/nearest_reference_color_classifier.sv
// ----------------------------------------------------------------------------
// nearest_reference_color_classifier
// Pipelined nearest reference colour match on raw sensor readings.
// ----------------------------------------------------------------------------
// A reading is transferred when start is high and busy is low; busy is always
// low, so one reading may enter every cycle. The sum of squares is formed in
// two stages, the magnitude by a 17-stage restoring square root pipeline, and
// each normalised channel by a 24-stage restoring divider (one quotient bit
// per stage over the full dividend). Weighted distances to all references
// are then formed in stages P and Q, divided by 10000 with a reciprocal step
// and a registered correction, and reduced by a minimum in front of the
// output register. Between a transferred reading and its result lie the 2
// sum stages, the 17 root stages, the 24 divider stages and 6 stages of
// normalisation, distance search and output; throughput is one reading per
// cycle. Each result appears on the result ports for one cycle with done high
// and cannot be held off. Reset clears the valid bits and restores the
// configuration registers to their reset values.
// Configuration is written through cfg_we, cfg_index and cfg_data and takes
// effect at once.
// ----------------------------------------------------------------------------
`default_nettype none
module nearest_reference_color_classifier
    import nrcc_pkg::*;
#(
    parameter int MAX_COLORS = MAX_COLORS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [15:0] clear_raw,
    input  wire logic [15:0] red_raw,
    input  wire logic [15:0] green_raw,
    input  wire logic [15:0] blue_raw,
    input  wire logic        cfg_we,
    input  wire logic [3:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    output logic             done,
    output logic             match_found,
    output logic [2:0]       color_index,
    output logic [15:0]      best_distance,
    output logic [7:0]       norm_red,
    output logic [7:0]       norm_green,
    output logic [7:0]       norm_blue
);
    localparam int SQ_STAGES = MAG_W;
    localparam int DV_STAGES = 24;
    localparam int DV_W = 24;

    logic [15:0] thresh_reg;
    logic [2:0]  count_reg;
    logic [23:0] refc_reg [REG_SLOTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
            count_reg  <= COUNT_RESET;
            for (int i = 0; i < REG_SLOTS; i++)
            begin
                refc_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_THRESH)
            begin
                thresh_reg <= cfg_data[15:0];
            end
            else if (cfg_index == REG_COUNT)
            begin
                count_reg <= cfg_data[2:0];
            end
            else
            begin
                for (int i = 0; i < REG_SLOTS; i++)
                begin
                    if (cfg_index == REG_COLOR0 + 4'(i))
                    begin
                        refc_reg[i] <= cfg_data;
                    end
                end
            end
        end
    end

    assign busy = 1'b0;

    // Stage A: squares; stage B: sum.
    logic        a_v_reg;
    logic        a_ok_reg;
    logic [15:0] a_c_reg [3];
    logic [31:0] a_sq_reg [3];
    logic        b_v_reg;
    logic        b_ok_reg;
    logic [15:0] b_c_reg [3];
    logic [SUM_W-1:0] b_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
        end
        else
        begin
            a_v_reg <= start;
            b_v_reg <= a_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_ok_reg   <= clear_raw >= thresh_reg;
        a_c_reg[0] <= red_raw;
        a_c_reg[1] <= green_raw;
        a_c_reg[2] <= blue_raw;
        a_sq_reg[0] <= red_raw * red_raw;
        a_sq_reg[1] <= green_raw * green_raw;
        a_sq_reg[2] <= blue_raw * blue_raw;
        b_ok_reg   <= a_ok_reg;
        b_c_reg    <= a_c_reg;
        b_sum_reg  <= SUM_W'(a_sq_reg[0]) + SUM_W'(a_sq_reg[1]) + SUM_W'(a_sq_reg[2]);
    end

    // Square root: one result bit per stage, most significant first.
    logic             s_v_reg   [SQ_STAGES+1];
    logic             s_ok_reg  [SQ_STAGES+1];
    logic [15:0]      s_c_reg   [SQ_STAGES+1][3];
    logic [SUM_W:0]   s_rem_reg [SQ_STAGES+1];
    logic [MAG_W-1:0] s_q_reg   [SQ_STAGES+1];

    always_comb
    begin
        s_v_reg[0]   = b_v_reg;
        s_ok_reg[0]  = b_ok_reg;
        s_c_reg[0]   = b_c_reg;
        s_rem_reg[0] = {1'b0, b_sum_reg};
        s_q_reg[0]   = '0;
    end

    for (genvar k = 0; k < SQ_STAGES; k++)
    begin : g_sqrt
        localparam int SH = 2 * (SQ_STAGES - 1 - k);
        logic [SUM_W:0] trial;
        logic [SUM_W:0] qx;
        assign qx    = (SUM_W+1)'(s_q_reg[k]);
        assign trial = ((qx << 2) | (SUM_W+1)'(1)) << SH;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                s_v_reg[k+1] <= 1'b0;
            end
            else
            begin
                s_v_reg[k+1] <= s_v_reg[k];
            end
        end
        always_ff @(posedge clk)
        begin
            s_ok_reg[k+1] <= s_ok_reg[k];
            s_c_reg[k+1]  <= s_c_reg[k];
            if (s_rem_reg[k] >= trial)
            begin
                s_rem_reg[k+1] <= s_rem_reg[k] - trial;
                s_q_reg[k+1]   <= {s_q_reg[k][MAG_W-2:0], 1'b1};
            end
            else
            begin
                s_rem_reg[k+1] <= s_rem_reg[k];
                s_q_reg[k+1]   <= {s_q_reg[k][MAG_W-2:0], 1'b0};
            end
        end
    end

    // Dividers: c*255 / mag, restoring, one quotient bit per stage.
    logic             d_v_reg   [DV_STAGES+1];
    logic             d_ok_reg  [DV_STAGES+1];
    logic             d_z_reg   [DV_STAGES+1];
    logic [MAG_W-1:0] d_m_reg   [DV_STAGES+1];
    logic [DV_W-1:0]  d_n_reg   [DV_STAGES+1][3];
    logic [MAG_W:0]   d_r_reg   [DV_STAGES+1][3];

    always_comb
    begin
        d_v_reg[0]  = s_v_reg[SQ_STAGES];
        d_ok_reg[0] = s_ok_reg[SQ_STAGES];
        d_m_reg[0]  = s_q_reg[SQ_STAGES];
        d_z_reg[0]  = s_q_reg[SQ_STAGES] == '0;
        for (int j = 0; j < 3; j++)
        begin
            d_n_reg[0][j] = DV_W'({s_c_reg[SQ_STAGES][j], 8'd0})
                            - DV_W'(s_c_reg[SQ_STAGES][j]);
            d_r_reg[0][j] = '0;
        end
    end

    for (genvar k = 0; k < DV_STAGES; k++)
    begin : g_div
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                d_v_reg[k+1] <= 1'b0;
            end
            else
            begin
                d_v_reg[k+1] <= d_v_reg[k];
            end
        end
        for (genvar j = 0; j < 3; j++)
        begin : g_ch
            logic [MAG_W:0] sh;
            assign sh = {d_r_reg[k][j][MAG_W-1:0], d_n_reg[k][j][DV_W-1]};
            always_ff @(posedge clk)
            begin
                if (sh >= {1'b0, d_m_reg[k]})
                begin
                    d_r_reg[k+1][j] <= sh - {1'b0, d_m_reg[k]};
                    d_n_reg[k+1][j] <= {d_n_reg[k][j][DV_W-2:0], 1'b1};
                end
                else
                begin
                    d_r_reg[k+1][j] <= sh;
                    d_n_reg[k+1][j] <= {d_n_reg[k][j][DV_W-2:0], 1'b0};
                end
            end
        end
        always_ff @(posedge clk)
        begin
            d_ok_reg[k+1] <= d_ok_reg[k];
            d_z_reg[k+1]  <= d_z_reg[k];
            d_m_reg[k+1]  <= d_m_reg[k];
        end
    end

    // Stage N: normalised channels.
    logic  n_v_reg;
    logic  n_ok_reg;
    norm_t n_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_v_reg <= 1'b0;
        end
        else
        begin
            n_v_reg <= d_v_reg[DV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        n_ok_reg <= d_ok_reg[DV_STAGES];
        if (d_z_reg[DV_STAGES])
        begin
            n_reg <= '0;
        end
        else
        begin
            n_reg.red   <= d_n_reg[DV_STAGES][0][7:0];
            n_reg.green <= d_n_reg[DV_STAGES][1][7:0];
            n_reg.blue  <= d_n_reg[DV_STAGES][2][7:0];
        end
    end

    // Stage P: weighted squared differences; stage Q: sum; stage R: reciprocal
    // product; stage T: corrected quotient.
    logic  p_v_reg, q_v_reg, r_v_reg, t_v_reg;
    logic  p_ok_reg, q_ok_reg, r_ok_reg, t_ok_reg;
    norm_t p_n_reg, q_n_reg, r_n_reg, t_n_reg;
    logic [28:0] p_t_reg [MAX_COLORS][3];
    logic [28:0] q_s_reg [MAX_COLORS];
    logic [51:0] r_p_reg [MAX_COLORS];
    logic [28:0] r_s_reg [MAX_COLORS];
    logic [DIST_W-1:0] t_d_reg [MAX_COLORS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_v_reg <= 1'b0;
            q_v_reg <= 1'b0;
            r_v_reg <= 1'b0;
            t_v_reg <= 1'b0;
        end
        else
        begin
            p_v_reg <= n_v_reg;
            q_v_reg <= p_v_reg;
            r_v_reg <= q_v_reg;
            t_v_reg <= r_v_reg;
        end
    end

    for (genvar i = 0; i < MAX_COLORS; i++)
    begin : g_col
        logic [7:0] dr, dg, db;
        logic [7:0] cr, cg, cb;
        logic [15:0] qe;
        logic [28:0] rem;
        assign cr = refc_reg[i][23:16];
        assign cg = refc_reg[i][15:8];
        assign cb = refc_reg[i][7:0];
        assign dr = n_reg.red > cr ? n_reg.red - cr : cr - n_reg.red;
        assign dg = n_reg.green > cg ? n_reg.green - cg : cg - n_reg.green;
        assign db = n_reg.blue > cb ? n_reg.blue - cb : cb - n_reg.blue;
        assign qe  = r_p_reg[i][51:36];
        assign rem = r_s_reg[i] - 29'(qe) * 29'd10000;
        always_ff @(posedge clk)
        begin
            p_t_reg[i][0] <= 29'(W_RED) * 29'(dr) * 29'(dr);
            p_t_reg[i][1] <= 29'(W_GREEN) * 29'(dg) * 29'(dg);
            p_t_reg[i][2] <= 29'(W_BLUE) * 29'(db) * 29'(db);
            q_s_reg[i] <= p_t_reg[i][0] + p_t_reg[i][1] + p_t_reg[i][2];
            r_p_reg[i] <= 52'(q_s_reg[i]) * 52'd6871947;
            r_s_reg[i] <= q_s_reg[i];
            t_d_reg[i] <= (rem >= 29'd10000) ? qe + 16'd1 : qe;
        end
    end

    always_ff @(posedge clk)
    begin
        p_ok_reg <= n_ok_reg;
        p_n_reg  <= n_reg;
        q_ok_reg <= p_ok_reg;
        q_n_reg  <= p_n_reg;
        r_ok_reg <= q_ok_reg;
        r_n_reg  <= q_n_reg;
        t_ok_reg <= r_ok_reg;
        t_n_reg  <= r_n_reg;
    end

    // Minimum over the colours in use.
    logic [2:0] used;
    logic              best_f;
    logic [2:0]        best_i;
    logic [DIST_W-1:0] best_d;

    assign used = (count_reg > 3'(MAX_COLORS)) ? 3'(MAX_COLORS) : count_reg;

    always_comb
    begin
        best_f = 1'b0;
        best_i = '0;
        best_d = NO_MATCH_DIST;
        for (int i = 0; i < MAX_COLORS; i++)
        begin
            if (t_ok_reg && (3'(i) < used) && (t_d_reg[i] < best_d))
            begin
                best_f = 1'b1;
                best_i = 3'(i);
                best_d = t_d_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
        end
        else
        begin
            done <= t_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        match_found   <= best_f;
        color_index   <= best_i;
        best_distance <= best_d;
        norm_red      <= t_n_reg.red;
        norm_green    <= t_n_reg.green;
        norm_blue     <= t_n_reg.blue;
    end
endmodule
`default_nettype wire
